FILE: rtl/levenshtein_edit_distance_macros.svh
// Assertion macros used by the checker file of the edit distance block.
`ifndef LEVENSHTEIN_EDIT_DISTANCE_MACROS_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/led_pkg.sv
package led_pkg;

    localparam int SYM_W  = 8;
    localparam int DIST_W = 9;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        FN_APPEND_A = 2'd0,
        FN_APPEND_B = 2'd1,
        FN_COMPUTE  = 2'd2
    } t_func;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_func             func;
        logic [SYM_W-1:0]  symbol;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_item;

    // Control fields of the stream that moves from cell to cell.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SYM_W-1:0] sym;
    } t_link;

    // Broadcast controls from the controller to every cell.
    typedef struct packed {
        logic             init;
        logic             clear;
        logic             wr_en;
        logic [SYM_W-1:0] sym;
    } t_cell_ctl;

endpackage

FILE: rtl/led_in_if.sv
interface led_in_if;
    import led_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/led_out_if.sv
interface led_out_if;
    import led_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/levenshtein_edit_distance.sv
// A compute transfer with either string empty skips the chain and gives the sum
// of the two lengths; otherwise the rows of B are fed through the chain of cells.
// Throughput: one append per cycle; a compute holds off input until the last
// row of B has left all MAX_LEN cells and the result is in the output register.
// Reset (synchronous, active low) empties both strings and clears the overflow
// flag and all handshake state; the stored bytes themselves are not cleared.
module levenshtein_edit_distance #(
    parameter int MAX_LEN = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    led_in_if.sink        i_in,
    led_out_if.source     o_out
);
    import led_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int COST_W = $clog2(MAX_LEN + 2);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state              r_state,    n_state;
    logic [LEN_W-1:0]    r_len_a,    n_len_a;
    logic [LEN_W-1:0]    r_len_b,    n_len_b;
    logic                r_ovf,      n_ovf;
    logic [LEN_W-1:0]    r_j,        n_j;
    logic [COST_W-1:0]   r_dist,     n_dist;
    logic                r_dist_ovf, n_dist_ovf;
    logic                r_o_valid,  n_o_valid;
    logic [DIST_W-1:0]   r_o_dist,   n_o_dist;
    logic                r_o_ovf,    n_o_ovf;

    logic                accept;
    logic                a_full;
    logic                b_full;
    logic                b_wr;
    logic                last_row;
    t_cell_ctl           ctl;

    t_link               w_link      [0:MAX_LEN];
    logic [COST_W-1:0]   w_cost      [0:MAX_LEN];
    logic                w_filled    [0:MAX_LEN+1];
    logic                w_res_valid [0:MAX_LEN];
    logic [COST_W-1:0]   w_res       [0:MAX_LEN];

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign a_full     = (r_len_a == LEN_W'(MAX_LEN));
    assign b_full     = (r_len_b == LEN_W'(MAX_LEN));
    assign b_wr       = accept && (i_in.payload.func == FN_APPEND_B) && !b_full;
    assign last_row   = (r_j == LEN_W'(r_len_b - LEN_W'(1)));

    // Next state, string lengths, cell controls and the output register.
    always_comb begin
        n_state    = r_state;
        n_len_a    = r_len_a;
        n_len_b    = r_len_b;
        n_ovf      = r_ovf;
        n_j        = r_j;
        n_dist     = r_dist;
        n_dist_ovf = r_dist_ovf;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_dist   = r_o_dist;
        n_o_ovf    = r_o_ovf;
        ctl.init   = 1'b0;
        ctl.clear  = 1'b0;
        ctl.wr_en  = 1'b0;
        ctl.sym    = i_in.payload.symbol;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.payload.func)
                        FN_APPEND_A: begin
                            if (a_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                ctl.wr_en = 1'b1;
                                n_len_a   = r_len_a + LEN_W'(1);
                            end
                        end
                        FN_APPEND_B: begin
                            if (b_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_len_b = r_len_b + LEN_W'(1);
                            end
                        end
                        FN_COMPUTE: begin
                            ctl.init = 1'b1;
                            if ((r_len_a == '0) || (r_len_b == '0)) begin
                                // Empty string: the distance is the other length.
                                n_dist     = COST_W'(r_len_a) + COST_W'(r_len_b);
                                n_dist_ovf = r_ovf;
                                n_len_a    = '0;
                                n_len_b    = '0;
                                n_ovf      = 1'b0;
                                ctl.clear  = 1'b1;
                                n_state    = ST_DONE;
                            end else begin
                                n_j     = '0;
                                n_state = ST_FEED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FEED: begin
                n_j = r_j + LEN_W'(1);
                if (last_row) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_res_valid[MAX_LEN]) begin
                    n_dist     = w_res[MAX_LEN];
                    n_dist_ovf = r_ovf;
                    n_len_a    = '0;
                    n_len_b    = '0;
                    n_ovf      = 1'b0;
                    ctl.clear  = 1'b1;
                    n_state    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_dist  = DIST_W'(r_dist);
                    n_o_ovf   = r_dist_ovf;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len_a   <= '0;
            r_len_b   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len_a   <= n_len_a;
            r_len_b   <= n_len_b;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_dist     <= n_dist;
        r_dist_ovf <= n_dist_ovf;
        r_o_dist   <= n_o_dist;
        r_o_ovf    <= n_o_ovf;
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.payload.distance = r_o_dist;
    assign o_out.payload.overflow = r_o_ovf;

    // String B store and the row feeder at the head of the chain.
    led_bfeed #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W),
        .COST_W (COST_W)
    ) u_bfeed (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (b_wr),
        .i_wr_addr (r_len_b[ADDR_W-1:0]),
        .i_wr_sym  (i_in.payload.symbol),
        .i_rd_en   (r_state == ST_FEED),
        .i_rd_addr (r_j[ADDR_W-1:0]),
        .i_row     (COST_W'(r_j) + COST_W'(1)),
        .i_last    (last_row),
        .o_link    (w_link[0]),
        .o_cost    (w_cost[0])
    );

    assign w_filled[0]         = 1'b1;
    assign w_filled[MAX_LEN+1] = 1'b0;
    assign w_res_valid[0]      = 1'b0;
    assign w_res[0]            = '0;

    // One cell per byte of string A; rows of B sweep through left to right.
    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        led_cell #(
            .IDX    (g),
            .COST_W (COST_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_left         (w_link[g-1]),
            .i_left_cost    (w_cost[g-1]),
            .i_left_filled  (w_filled[g-1]),
            .i_right_filled (w_filled[g+1]),
            .i_res_valid    (w_res_valid[g-1]),
            .i_res          (w_res[g-1]),
            .o_right        (w_link[g]),
            .o_cost         (w_cost[g]),
            .o_filled       (w_filled[g]),
            .o_res_valid    (w_res_valid[g]),
            .o_res          (w_res[g])
        );
    end

endmodule

FILE: rtl/led_cell.sv
module led_cell #(
    parameter int IDX    = 1,
    parameter int COST_W = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  led_pkg::t_cell_ctl    i_ctl,
    input  led_pkg::t_link        i_left,
    input  logic [COST_W-1:0]     i_left_cost,
    input  logic                  i_left_filled,
    input  logic                  i_right_filled,
    input  logic                  i_res_valid,
    input  logic [COST_W-1:0]     i_res,
    output led_pkg::t_link        o_right,
    output logic [COST_W-1:0]     o_cost,
    output logic                  o_filled,
    output logic                  o_res_valid,
    output logic [COST_W-1:0]     o_res
);
    import led_pkg::*;

    logic [SYM_W-1:0]  r_a;
    logic              r_filled;
    logic              r_valid;
    logic              r_last;
    logic [SYM_W-1:0]  r_sym;
    logic [COST_W-1:0] r_cost;
    logic [COST_W-1:0] r_diag;
    logic              r_res_valid;
    logic [COST_W-1:0] r_res;

    logic              wr_here;
    logic              hit;
    logic              mism;
    logic [COST_W-1:0] c_up;
    logic [COST_W-1:0] c_ins;
    logic [COST_W-1:0] c_sub;
    logic [COST_W-1:0] best;

    // The first empty cell of the row takes the appended byte of string A.
    assign wr_here = i_ctl.wr_en && !r_filled && i_left_filled;

    // This cell holds the last byte of A and sees the last row of B: the answer.
    assign hit = i_left.valid && i_left.last && r_filled && !i_right_filled;

    // One step of the recurrence: deletion, insertion or substitution.
    always_comb begin
        mism  = (r_a != i_left.sym);
        c_up  = r_cost + COST_W'(1);
        c_ins = i_left_cost + COST_W'(1);
        c_sub = r_diag + COST_W'(mism);
        best  = c_up;
        if (c_ins < best) begin
            best = c_ins;
        end
        if (c_sub < best) begin
            best = c_sub;
        end
    end

    // Control flags of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= 1'b0;
            r_valid     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_filled <= 1'b0;
            end else if (wr_here) begin
                r_filled <= 1'b1;
            end
            r_valid     <= i_left.valid;
            r_res_valid <= hit || i_res_valid;
        end
    end

    // Stored byte, column costs and the hand-over to the right neighbour.
    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_a <= i_ctl.sym;
        end
        r_last <= i_left.last;
        r_sym  <= i_left.sym;
        if (i_ctl.init) begin
            r_cost <= COST_W'(IDX);
            r_diag <= COST_W'(IDX - 1);
        end else if (i_left.valid) begin
            r_cost <= best;
            r_diag <= i_left_cost;
        end
        r_res <= hit ? best : i_res;
    end

    assign o_right.valid = r_valid;
    assign o_right.last  = r_last;
    assign o_right.sym   = r_sym;
    assign o_cost        = r_cost;
    assign o_filled      = r_filled;
    assign o_res_valid   = r_res_valid;
    assign o_res         = r_res;

endmodule

FILE: rtl/led_bfeed.sv
module led_bfeed #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int COST_W = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [7:0]            i_wr_sym,
    input  logic                  i_rd_en,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    input  logic [COST_W-1:0]     i_row,
    input  logic                  i_last,
    output led_pkg::t_link        o_link,
    output logic [COST_W-1:0]     o_cost
);
    import led_pkg::*;

    logic [SYM_W-1:0]  mem [0:DEPTH-1];
    logic              r_valid;
    logic              r_last;
    logic [SYM_W-1:0]  r_q;
    logic [COST_W-1:0] r_cost;

    // String B store; a read feeds one row into the head of the chain.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_sym;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
        r_cost <= i_row;
        r_last <= i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_rd_en;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.last  = r_last;
    assign o_link.sym   = r_q;
    assign o_cost       = r_cost;

endmodule

FILE: rtl/led_checker.sv
module led_checker #(
    parameter int MAX_LEN = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  led_pkg::t_func       i_in_func,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  led_pkg::t_out_item   i_out_payload
);
    import led_pkg::*;
    `include "levenshtein_edit_distance_macros.svh"

    // A waiting result keeps its value until it is taken.
    `LED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "result changed while stalled")

    // A compute transfer stops further input until the distance is done.
    `LED_ASSERT_NEXT(a_compute_blocks, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_func == FN_COMPUTE), !i_in_ready, "input taken during compute")

    // Appends never produce a result.
    `LED_ASSERT_NEXT(a_append_silent, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_func != FN_COMPUTE) && !i_out_valid, !i_out_valid, "result after an append")

    // A distance cannot exceed MAX_LEN; checked only where MAX_LEN is at most 256.
    `LED_ASSERT_NOW(a_dist_range, i_clk, i_rst_n, i_out_valid && (MAX_LEN <= 256), i_out_payload.distance <= MAX_LEN, "distance out of range")

endmodule

bind levenshtein_edit_distance led_checker #(.MAX_LEN(MAX_LEN)) u_led_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_func     (i_in.payload.func),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
